FILE: rtl/aweq_pkg.sv
// ----------------------------------------------------------------------------
// aweq_pkg
// Shared widths, register codes and types for the wheel encoder qualifier.
// ----------------------------------------------------------------------------
package aweq_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_BITS = 12;
  localparam int TICK_BITS   = 16;
  localparam int STEP_BITS   = 16;
  localparam int SPEED_BITS  = 13;
  localparam int LIMIT_BITS  = 8;
  localparam int CONF_BITS   = 9;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 13;

  // Period timer and divider
  localparam int TIMER_BITS     = 16;
  localparam int PERIOD_DIVISOR = 10;

  // Exact reciprocal divide: q = (t * DIV_MULT) >> DIV_SHIFT for all t < 2**TIMER_BITS
  localparam int DIV_SHIFT     = TIMER_BITS + $clog2(PERIOD_DIVISOR);
  localparam int DIV_MULT_BITS = TIMER_BITS + 1;
  localparam int PROD_BITS     = TIMER_BITS + DIV_MULT_BITS;
  localparam logic [63:0] DIV_MULT =
    ((64'd1 << DIV_SHIFT) + 64'(PERIOD_DIVISOR) - 64'd1) / 64'(PERIOD_DIVISOR);
  localparam int CMP_BITS = (TIMER_BITS > SPEED_BITS) ? TIMER_BITS : SPEED_BITS;

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = SAMPLE_BITS'(3400);
  localparam logic [SAMPLE_BITS-1:0] BAND_RST      = SAMPLE_BITS'(350);
  localparam logic [LIMIT_BITS-1:0]  LIMIT_RST     = LIMIT_BITS'(5);
  localparam logic [SPEED_BITS-1:0]  CEILING_RST   = SPEED_BITS'(2300);

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LEFT_THRESHOLD  = 3'd0,
    CFG_RIGHT_THRESHOLD = 3'd1,
    CFG_BAND_HALF_WIDTH = 3'd2,
    CFG_CONF_LIMIT      = 3'd3,
    CFG_SPEED_CEILING   = 3'd4
  } cfg_idx_t;

  // Current register contents
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left_threshold;
    logic [SAMPLE_BITS-1:0] right_threshold;
    logic [SAMPLE_BITS-1:0] band_half_width;
    logic [LIMIT_BITS-1:0]  confidence_limit;
    logic [SPEED_BITS-1:0]  speed_ceiling;
  } cfg_t;

  // Per-channel result held for the output side
  typedef struct packed {
    logic                  level;
    logic [STEP_BITS-1:0]  steps;
    logic [SPEED_BITS-1:0] speed;
    logic                  speed_new;
  } chan_res_t;

endpackage

FILE: rtl/aweq_cfg.sv
// ----------------------------------------------------------------------------
// aweq_cfg
// Configuration register file; written by index, no read-back.
// ----------------------------------------------------------------------------
module aweq_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [aweq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [aweq_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output aweq_pkg::cfg_t                  cfg
);
  import aweq_pkg::*;

  // Write the addressed register; ignore indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_threshold   <= THRESHOLD_RST;
      cfg.right_threshold  <= THRESHOLD_RST;
      cfg.band_half_width  <= BAND_RST;
      cfg.confidence_limit <= LIMIT_RST;
      cfg.speed_ceiling    <= CEILING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEFT_THRESHOLD:  cfg.left_threshold   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_RIGHT_THRESHOLD: cfg.right_threshold  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_BAND_HALF_WIDTH: cfg.band_half_width  <= cfg_data[SAMPLE_BITS-1:0];
        CFG_CONF_LIMIT:      cfg.confidence_limit <= cfg_data[LIMIT_BITS-1:0];
        CFG_SPEED_CEILING:   cfg.speed_ceiling    <= cfg_data[SPEED_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/aweq_chan.sv
// ----------------------------------------------------------------------------
// aweq_chan
// One encoder channel: hysteresis debounce, step count, period timer, speed.
// ----------------------------------------------------------------------------
module aweq_chan (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic [aweq_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [aweq_pkg::TICK_BITS-1:0]   ticks,
  input  logic [aweq_pkg::SAMPLE_BITS-1:0] threshold,
  input  aweq_pkg::cfg_t                 cfg,
  output aweq_pkg::chan_res_t            res
);
  import aweq_pkg::*;

  logic [CONF_BITS-1:0]   conf;
  logic [TIMER_BITS-1:0]  timer;

  logic [SAMPLE_BITS:0]   sample_x;
  logic [SAMPLE_BITS:0]   upper;
  logic                   above;
  logic                   below;
  logic                   disagree;
  logic [CONF_BITS-1:0]   conf_inc;
  logic                   flip;
  logic [TIMER_BITS-1:0]  timer_add;
  logic [PROD_BITS-1:0]   prod;
  logic [TIMER_BITS-1:0]  scaled;
  logic                   over;
  logic [SPEED_BITS-1:0]  speed_calc;

  chan_res_t              res_next;
  logic [CONF_BITS-1:0]   conf_next;
  logic [TIMER_BITS-1:0]  timer_next;

  // Hysteresis compare; lower bound written as sample + band < threshold
  assign sample_x = {1'b0, sample};
  assign upper    = {1'b0, threshold} + {1'b0, cfg.band_half_width};
  assign above    = sample_x > upper;
  assign below    = (sample_x + {1'b0, cfg.band_half_width}) < {1'b0, threshold};
  assign disagree = (above && !res.level) || (below && res.level);

  // Confidence count and flip decision
  assign conf_inc = conf + CONF_BITS'(1);
  assign flip     = disagree && (conf_inc > {1'b0, cfg.confidence_limit});

  // Advance timer, divide by the period divisor through the reciprocal
  assign timer_add = timer + TIMER_BITS'(ticks);
  assign prod      = PROD_BITS'(timer_add) * PROD_BITS'(DIV_MULT);
  assign scaled    = TIMER_BITS'(prod >> DIV_SHIFT);
  assign over      = CMP_BITS'(scaled) > CMP_BITS'(cfg.speed_ceiling);
  assign speed_calc = over ? '0 : cfg.speed_ceiling - SPEED_BITS'(scaled);

  // Next channel state
  always_comb begin
    res_next.level     = res.level ^ flip;
    res_next.steps     = res.steps + STEP_BITS'(flip);
    res_next.speed_new = flip && res.level;
    res_next.speed     = (flip && res.level) ? speed_calc : res.speed;
    conf_next          = (disagree && !flip) ? conf_inc : '0;
    timer_next         = (flip && !res.level) ? '0 : timer_add;
  end

  // Hold state; update once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      res   <= '0;
      conf  <= '0;
      timer <= '0;
    end else if (adv) begin
      res   <= res_next;
      conf  <= conf_next;
      timer <= timer_next;
    end
  end

`ifndef SYNTHESIS
  // A new speed only follows a falling flip that advanced the step count
  a_speed_on_fall: assert property (@(posedge clk) disable iff (rst)
    ($past(adv) && res.speed_new) |->
      (!res.level && res.steps == $past(res.steps) + STEP_BITS'(1)))
    else $error("speed update without falling flip");

  // A flip clears the confidence count
  a_flip_clears_conf: assert property (@(posedge clk) disable iff (rst)
    ($past(adv) && res.level != $past(res.level)) |-> conf == '0)
    else $error("confidence not cleared on flip");

  // State holds between items
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(res) && $stable(conf) && $stable(timer)))
    else $error("channel state changed without an item");
`endif

endmodule

FILE: rtl/analog_wheel_encoder_qualifier_top.sv
// ----------------------------------------------------------------------------
// analog_wheel_encoder_qualifier_top
// Two-channel optical wheel encoder qualifier: debounced levels, step counts
// and period-based speed from a stream of ADC sample pairs.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | in_valid/in_stall  | left_sample, right_sample, elapsed_ticks
//  out      | out_valid/out_stall| left/right level, steps, speed, speed_new
//  cfg      | cfg_we             | cfg_index, cfg_data
//
//  One item per cycle while the output is not stalled; each accepted item
//  passes the input register and then the channel state, which doubles as
//  result register, before its result shows at the output.
//  The critical path is the timer add, reciprocal multiply and clamp.
//  Sync active-high reset clears valids and channel state, loads cfg defaults.
//  While the output is stalled one more item is taken into the input register.
// ----------------------------------------------------------------------------
module analog_wheel_encoder_qualifier_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [aweq_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [aweq_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [aweq_pkg::SAMPLE_BITS-1:0]   left_sample,
  input  logic [aweq_pkg::SAMPLE_BITS-1:0]   right_sample,
  input  logic [aweq_pkg::TICK_BITS-1:0]     elapsed_ticks,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              left_level,
  output logic                              right_level,
  output logic [aweq_pkg::STEP_BITS-1:0]     left_steps,
  output logic [aweq_pkg::STEP_BITS-1:0]     right_steps,
  output logic [aweq_pkg::SPEED_BITS-1:0]    left_speed,
  output logic [aweq_pkg::SPEED_BITS-1:0]    right_speed,
  output logic                              left_speed_new,
  output logic                              right_speed_new
);
  import aweq_pkg::*;

  cfg_t                   cfg;
  chan_res_t              left_res;
  chan_res_t              right_res;

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_left;
  logic [SAMPLE_BITS-1:0] s1_right;
  logic [TICK_BITS-1:0]   s1_ticks;

  logic                   out_ready;
  logic                   adv;
  logic                   in_take;

  // Flow control
  assign out_ready = !out_valid || !out_stall;
  assign adv       = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_take   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_left  <= left_sample;
      s1_right <= right_sample;
      s1_ticks <= elapsed_ticks;
    end
  end

  // Result valid: set on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  aweq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  aweq_chan u_left (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .sample    (s1_left),
    .ticks     (s1_ticks),
    .threshold (cfg.left_threshold),
    .cfg       (cfg),
    .res       (left_res)
  );

  aweq_chan u_right (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .sample    (s1_right),
    .ticks     (s1_ticks),
    .threshold (cfg.right_threshold),
    .cfg       (cfg),
    .res       (right_res)
  );

  // Drive result fields from channel state
  assign left_level      = left_res.level;
  assign right_level     = right_res.level;
  assign left_steps      = left_res.steps;
  assign right_steps     = right_res.steps;
  assign left_speed      = left_res.speed;
  assign right_speed     = right_res.speed;
  assign left_speed_new  = left_res.speed_new;
  assign right_speed_new = right_res.speed_new;

`ifndef SYNTHESIS
  // Input side stalls only behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without backpressure");

  // An advanced item always shows up as a result
  a_adv_shows: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("advanced item not presented");

  // A held input item is not dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> s1_valid)
    else $error("input item lost");
`endif

endmodule
